/* rtl/dcipc_pkg.sv */
// Shared types and constants for the dual CPU mailbox.
`timescale 1ns / 1ps
`default_nettype none

package dcipc_pkg;

    // Access kinds carried in the low bits of the input tuser.
    typedef enum logic [1:0] {
        OP_SYNC = 2'd0,
        OP_CTRL = 2'd1,
        OP_SEND = 2'd2,
        OP_RECV = 2'd3
    } t_op;

    // Stream widths.
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;

    // Writable bit masks of the sync and FIFO control registers.
    localparam logic [15:0] SYNC_WR_MASK = 16'h4F00;
    localparam logic [15:0] CTL_WR_MASK  = 16'h8404;

    // FIFO control register bit positions.
    localparam int CB_SEND_EMPTY = 0;
    localparam int CB_SEND_FULL  = 1;
    localparam int CB_SEND_IRQ   = 2;
    localparam int CB_CLEAR      = 3;
    localparam int CB_RECV_EMPTY = 8;
    localparam int CB_RECV_FULL  = 9;
    localparam int CB_RECV_IRQ   = 10;
    localparam int CB_ERROR      = 14;
    localparam int CB_ENABLE     = 15;

    // Sync register bits.
    localparam int SB_IRQ_REQ = 13;
    localparam int SB_IRQ_EN  = 14;

    localparam logic [15:0] CTL_RESET = 16'h0101;

    // IRQ pulse mask bit positions.
    localparam int IRQ_SYNC  = 0;
    localparam int IRQ_SEMPT = 1;
    localparam int IRQ_RECV  = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctl_cmd;

endpackage

`default_nettype wire

/* rtl/dcipc_ctrl.sv */
// Sequencing state machine of the dual CPU mailbox.
`timescale 1ns / 1ps
`default_nettype none

module dcipc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output dcipc_pkg::t_ctl_cmd o_cmd
);
    import dcipc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    t_state r_state;
    logic   r_s_tready;
    logic   r_m_tvalid;

    assign o_s_tready  = r_s_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_cmd.capture = i_s_tvalid && r_s_tready;
    assign o_cmd.exec    = (r_state == ST_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s_tready <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state    <= ST_EXEC;
                        r_s_tready <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    r_state    <= ST_OUT;
                    r_m_tvalid <= 1'b1;
                end
                ST_OUT: begin
                    if (i_m_tready) begin
                        r_state    <= ST_IDLE;
                        r_m_tvalid <= 1'b0;
                        r_s_tready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_s_tready <= 1'b1;
                    r_m_tvalid <= 1'b0;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("accepted beat was not executed in the next cycle");

    a_exec_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (o_m_tvalid && !o_s_tready))
        else $error("result not presented after execution");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result beat dropped before the sink took it");
`endif

endmodule

`default_nettype wire

/* rtl/dcipc_datapath.sv */
// Register file, FIFO storage and access logic of the dual CPU mailbox.
`timescale 1ns / 1ps
`default_nettype none

module dcipc_datapath #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  dcipc_pkg::t_ctl_cmd            i_cmd,
    input  wire  [dcipc_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  wire  [dcipc_pkg::IN_USER_W-1:0]      i_s_tuser,
    output logic [dcipc_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import dcipc_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int HW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int SW = HW + 1;
    localparam int AW = $clog2(2 * FIFO_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] DEPTH_M1 = CW'(FIFO_DEPTH - 1);
    localparam logic [HW-1:0] HEAD_MAX = HW'(FIFO_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(FIFO_DEPTH);
    localparam logic [AW-1:0] DEPTH_A  = AW'(FIFO_DEPTH);

    // Captured access.
    t_op         r_op;
    logic        r_cpu;
    logic [31:0] r_mask;
    logic [31:0] r_value;

    // Architectural state, one entry per CPU.
    logic [1:0][15:0]   r_sync,  n_sync;
    logic [1:0][15:0]   r_ctl,   n_ctl;
    logic [1:0][31:0]   r_latch, n_latch;
    logic [1:0][HW-1:0] r_head,  n_head;
    logic [1:0][CW-1:0] r_count, n_count;

    logic [31:0] r_mem [2*FIFO_DEPTH];
    logic [31:0] r_rd_q;
    logic [OUT_DATA_W-1:0] r_out;

    logic            p_idx;
    logic            in_partner;
    logic [HW-1:0]   in_p_head;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [SW-1:0]   slot_sum;
    logic [HW-1:0]   slot;
    logic            wr_en;
    logic [31:0]     wr_data;

    logic [15:0]   v16, m16, mm;
    logic [15:0]   c_sync, p_sync, nc_sync, np_sync;
    logic [15:0]   c_ctl, p_ctl, nc_ctl, np_ctl;
    logic [31:0]   c_latch, p_latch, nc_latch, np_latch;
    logic [HW-1:0] c_head, p_head, nc_head, np_head;
    logic [CW-1:0] c_cnt, p_cnt, nc_cnt, np_cnt;
    logic [2:0]    irq_c, irq_p;
    logic [31:0]   rd;
    logic [2:0]    irq_first, irq_second;

    // The receive read looks at the partner's head, fetched while the beat is taken.
    assign in_partner = ~i_s_tuser[2];
    assign in_p_head  = in_partner ? r_head[1] : r_head[0];
    assign rd_addr    = (in_partner ? DEPTH_A : '0) + AW'(in_p_head);

    assign p_idx   = ~r_cpu;
    assign v16     = r_value[15:0];
    assign m16     = r_mask[15:0];
    assign c_sync  = r_cpu ? r_sync[1]  : r_sync[0];
    assign p_sync  = r_cpu ? r_sync[0]  : r_sync[1];
    assign c_ctl   = r_cpu ? r_ctl[1]   : r_ctl[0];
    assign p_ctl   = r_cpu ? r_ctl[0]   : r_ctl[1];
    assign c_latch = r_cpu ? r_latch[1] : r_latch[0];
    assign p_latch = r_cpu ? r_latch[0] : r_latch[1];
    assign c_head  = r_cpu ? r_head[1]  : r_head[0];
    assign p_head  = r_cpu ? r_head[0]  : r_head[1];
    assign c_cnt   = r_cpu ? r_count[1] : r_count[0];
    assign p_cnt   = r_cpu ? r_count[0] : r_count[1];

    // Tail slot of the caller's send FIFO: head plus count, wrapped once.
    assign slot_sum = SW'(c_head) + SW'(c_cnt);
    assign slot     = (slot_sum >= DEPTH_S) ? HW'(slot_sum - DEPTH_S) : HW'(slot_sum);
    assign wr_addr  = (r_cpu ? DEPTH_A : '0) + AW'(slot);
    assign wr_data  = r_value & r_mask;

    always_comb begin
        nc_sync  = c_sync;
        np_sync  = p_sync;
        nc_ctl   = c_ctl;
        np_ctl   = p_ctl;
        nc_latch = c_latch;
        np_latch = p_latch;
        nc_head  = c_head;
        np_head  = p_head;
        nc_cnt   = c_cnt;
        np_cnt   = p_cnt;
        mm       = '0;
        irq_c    = '0;
        irq_p    = '0;
        wr_en    = 1'b0;
        rd       = '0;

        case (r_op)
            OP_SYNC: begin
                mm = m16 & SYNC_WR_MASK;
                nc_sync = (c_sync & ~mm) | (v16 & mm);
                np_sync = {p_sync[15:4], (p_sync[3:0] & ~mm[11:8]) | (v16[11:8] & mm[11:8])};
                if (v16[SB_IRQ_REQ] && p_sync[SB_IRQ_EN]) begin
                    irq_p[IRQ_SYNC] = 1'b1;
                end
            end
            OP_CTRL: begin
                // Clear only acts on a non-empty send FIFO.
                if (v16[CB_CLEAR] && (c_cnt != '0)) begin
                    nc_cnt   = '0;
                    nc_head  = '0;
                    np_latch = '0;
                    nc_ctl[CB_SEND_EMPTY] = 1'b1;
                    nc_ctl[CB_SEND_FULL]  = 1'b0;
                    np_ctl[CB_RECV_EMPTY] = 1'b1;
                    np_ctl[CB_RECV_FULL]  = 1'b0;
                    if (nc_ctl[CB_SEND_IRQ]) begin
                        irq_c[IRQ_SEMPT] = 1'b1;
                    end
                end
                // Enabling an IRQ whose condition already holds fires it at once.
                if (nc_ctl[CB_SEND_EMPTY] && !nc_ctl[CB_SEND_IRQ] && v16[CB_SEND_IRQ]) begin
                    irq_c[IRQ_SEMPT] = 1'b1;
                end
                if (!nc_ctl[CB_RECV_EMPTY] && !nc_ctl[CB_RECV_IRQ] && v16[CB_RECV_IRQ]) begin
                    irq_c[IRQ_RECV] = 1'b1;
                end
                if (v16[CB_ERROR]) begin
                    nc_ctl[CB_ERROR] = 1'b0;
                end
                mm = m16 & CTL_WR_MASK;
                nc_ctl = (nc_ctl & ~mm) | (v16 & mm);
            end
            OP_SEND: begin
                if (c_ctl[CB_ENABLE]) begin
                    if (c_cnt >= DEPTH_C) begin
                        nc_ctl[CB_ERROR] = 1'b1;
                    end else begin
                        wr_en  = 1'b1;
                        nc_cnt = c_cnt + 1'b1;
                        if (nc_cnt == CW'(1)) begin
                            nc_ctl[CB_SEND_EMPTY] = 1'b0;
                            np_ctl[CB_RECV_EMPTY] = 1'b0;
                            if (p_ctl[CB_RECV_IRQ]) begin
                                irq_p[IRQ_RECV] = 1'b1;
                            end
                        end else if (nc_cnt == DEPTH_C) begin
                            nc_ctl[CB_SEND_FULL] = 1'b1;
                            np_ctl[CB_RECV_FULL] = 1'b1;
                        end
                    end
                end
            end
            OP_RECV: begin
                if (p_cnt == '0) begin
                    nc_ctl[CB_ERROR] = 1'b1;
                end else begin
                    nc_latch = r_rd_q;
                    // A disabled receiver only peeks at the head word.
                    if (c_ctl[CB_ENABLE]) begin
                        np_head = (p_head == HEAD_MAX) ? '0 : p_head + 1'b1;
                        np_cnt  = p_cnt - 1'b1;
                        if (np_cnt == '0) begin
                            nc_ctl[CB_RECV_EMPTY] = 1'b1;
                            np_ctl[CB_SEND_EMPTY] = 1'b1;
                            if (p_ctl[CB_SEND_IRQ]) begin
                                irq_p[IRQ_SEMPT] = 1'b1;
                            end
                        end else if (np_cnt == DEPTH_M1) begin
                            nc_ctl[CB_RECV_FULL] = 1'b0;
                            np_ctl[CB_SEND_FULL] = 1'b0;
                        end
                    end
                end
                rd = nc_latch;
            end
            default: begin
                rd = '0;
            end
        endcase

        n_sync  = r_sync;
        n_ctl   = r_ctl;
        n_latch = r_latch;
        n_head  = r_head;
        n_count = r_count;
        n_sync[r_cpu]  = nc_sync;
        n_sync[p_idx]  = np_sync;
        n_ctl[r_cpu]   = nc_ctl;
        n_ctl[p_idx]   = np_ctl;
        n_latch[r_cpu] = nc_latch;
        n_latch[p_idx] = np_latch;
        n_head[r_cpu]  = nc_head;
        n_head[p_idx]  = np_head;
        n_count[r_cpu] = nc_cnt;
        n_count[p_idx] = np_cnt;
    end

    assign irq_first  = r_cpu ? irq_p : irq_c;
    assign irq_second = r_cpu ? irq_c : irq_p;

    // Captured beat and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_s_tuser[1:0]);
            r_cpu   <= i_s_tuser[2];
            r_mask  <= i_s_tdata[31:0];
            r_value <= i_s_tdata[63:32];
        end
        if (i_cmd.exec) begin
            r_out <= {2'b00, irq_second, irq_first, nc_ctl, nc_sync, rd};
        end
    end

    // FIFO storage for both directions.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.capture) begin
            r_rd_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= '0;
            r_ctl   <= {CTL_RESET, CTL_RESET};
            r_latch <= '0;
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_sync  <= n_sync;
            r_ctl   <= n_ctl;
            r_latch <= n_latch;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_m_tdata = r_out;

`ifndef NO_ASSERTIONS
    a_empty_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[0][CB_SEND_EMPTY] == (r_count[0] == '0)) &&
        (r_ctl[1][CB_RECV_EMPTY] == (r_count[0] == '0)) &&
        (r_ctl[1][CB_SEND_EMPTY] == (r_count[1] == '0)) &&
        (r_ctl[0][CB_RECV_EMPTY] == (r_count[1] == '0)))
        else $error("empty flags disagree with FIFO fill");

    a_full_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[0][CB_SEND_FULL] == (r_count[0] == DEPTH_C)) &&
        (r_ctl[1][CB_RECV_FULL] == (r_count[0] == DEPTH_C)) &&
        (r_ctl[1][CB_SEND_FULL] == (r_count[1] == DEPTH_C)) &&
        (r_ctl[0][CB_RECV_FULL] == (r_count[1] == DEPTH_C)))
        else $error("full flags disagree with FIFO fill");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= DEPTH_C) && (r_count[1] <= DEPTH_C))
        else $error("FIFO fill beyond depth");
`endif

endmodule

`default_nettype wire

/* rtl/dual_cpu_ipc_sync_and_fifo.sv */
// Top level of the dual CPU mailbox: controller, datapath and stream ports.
// A result beat goes valid after its access beat is taken and then executed in the EXEC state.
// The block takes no new access until the sink has taken the previous result beat.
// The FIFO word of a receive is fetched from the storage RAM in the accept cycle.
// Reset (synchronous, active low) clears sync registers, latches and FIFO pointers,
// and sets both control registers to both-empty; FIFO storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dual_cpu_ipc_sync_and_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Access beats.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // tdata: bit_mask[31:0], write_value[63:32]
    input  wire  [dcipc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: cmd[1:0], cpu_sel[2]
    input  wire  [dcipc_pkg::IN_USER_W-1:0]  i_s_tuser,
    // Result beats.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // tdata: read_data[31:0], sync_now[47:32], control_now[63:48],
    //        irq_first_cpu[66:64], irq_second_cpu[69:67], zero[71:70]
    output logic [dcipc_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import dcipc_pkg::*;

    // Command bundle from the sequencer: capture loads the access beat and
    // starts the FIFO read, exec applies the access to the register state and
    // loads the result register, which holds until the sink takes the beat.
    t_ctl_cmd cmd;

    dcipc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // The datapath holds both CPUs' registers and the two send FIFOs, which
    // share a single storage RAM with one half per sending CPU.
    dcipc_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tdata (o_m_tdata)
    );

endmodule

`default_nettype wire

/* test/tb_dual_cpu_ipc_sync_and_fifo.sv */
// Self-checking stream testbench for the dual CPU mailbox with a register and FIFO predictor.
`timescale 1ns / 1ps

module tb_dual_cpu_ipc_sync_and_fifo;

    import dcipc_pkg::*;

    localparam int FIFO_DEPTH   = 16;
    localparam int ITEM_TARGET  = 1600;
    localparam int ITEM_CAP     = ITEM_TARGET + 64;
    localparam int PHASE_LEN    = 540;
    localparam int STALL_AT     = 1250;
    localparam int STALL_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 100;

    typedef struct {
        t_op         op;
        logic        cpu;
        logic [31:0] mask;
        logic [31:0] value;
    } t_access;

    typedef struct {
        logic [31:0] rdata;
        logic [15:0] sync;
        logic [15:0] ctl;
        logic [2:0]  irq_a;
        logic [2:0]  irq_b;
    } t_mailbox_result;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    dual_cpu_ipc_sync_and_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mailbox state as the predictor sees it.
    logic [15:0] sync_reg [2];
    logic [15:0] ctl_reg [2];
    logic [31:0] rx_latch [2];
    logic [31:0] fifo_words [2][FIFO_DEPTH];
    int          fifo_rd [2];
    int          fifo_cnt [2];

    // Pending accesses and expected results, each kept as an array with a
    // read and a write index.
    t_access         pending_mem [ITEM_CAP];
    t_mailbox_result expected_mem [ITEM_CAP];
    int              pend_head = 0;
    int              pend_tail = 0;
    int              exp_head  = 0;
    int              exp_tail  = 0;

    int  total_items  = 0;
    int  acc_cnt      = 0;
    int  beat_cnt     = 0;
    int  mismatch_cnt = 0;
    int  op_cnt [4]   = '{0, 0, 0, 0};
    int  n_overflow   = 0;
    int  n_underflow  = 0;
    int  n_peek       = 0;
    int  n_clear      = 0;
    int  n_full       = 0;
    bit  in_taken     = 1'b0;
    int  hold_left    = 0;
    bit  stall_done   = 1'b0;

    function automatic void mailbox_reset();
        for (int i = 0; i < 2; i++) begin
            sync_reg[i] = '0;
            ctl_reg[i]  = CTL_RESET;
            rx_latch[i] = '0;
            fifo_rd[i]  = 0;
            fifo_cnt[i] = 0;
        end
    endfunction

    // Applies one access to the mailbox state and returns the result beat it causes.
    function automatic t_mailbox_result mailbox_predict(t_access a);
        int              c;
        int              o;
        int              slot;
        logic [15:0]     m16;
        logic [15:0]     v16;
        logic [15:0]     mm;
        logic [15:0]     wr_bits;
        logic [2:0]      irq_v [2];
        t_mailbox_result r;
        c        = int'(a.cpu);
        o        = c ^ 1;
        m16      = a.mask[15:0];
        v16      = a.value[15:0];
        irq_v[0] = '0;
        irq_v[1] = '0;
        r.rdata  = '0;
        case (a.op)
            OP_SYNC: begin
                mm          = m16 & SYNC_WR_MASK;
                wr_bits     = v16 & mm;
                sync_reg[c] = (sync_reg[c] & ~mm) | wr_bits;
                // Written bits 11:8 land in the partner's bits 3:0.
                sync_reg[o] = (sync_reg[o] & ~{12'd0, mm[11:8]}) | {12'd0, wr_bits[11:8]};
                if (v16[SB_IRQ_REQ] && sync_reg[o][SB_IRQ_EN])
                    irq_v[o][IRQ_SYNC] = 1'b1;
            end
            OP_CTRL: begin
                if (v16[CB_CLEAR] && fifo_cnt[c] != 0) begin
                    n_clear++;
                    fifo_cnt[c]               = 0;
                    fifo_rd[c]                = 0;
                    rx_latch[o]               = '0;
                    ctl_reg[c][CB_SEND_EMPTY] = 1'b1;
                    ctl_reg[c][CB_SEND_FULL]  = 1'b0;
                    ctl_reg[o][CB_RECV_EMPTY] = 1'b1;
                    ctl_reg[o][CB_RECV_FULL]  = 1'b0;
                    if (ctl_reg[c][CB_SEND_IRQ])
                        irq_v[c][IRQ_SEMPT] = 1'b1;
                end
                // Enabling an IRQ whose condition already holds fires it at once.
                if (ctl_reg[c][CB_SEND_EMPTY] && !ctl_reg[c][CB_SEND_IRQ] && v16[CB_SEND_IRQ])
                    irq_v[c][IRQ_SEMPT] = 1'b1;
                if (!ctl_reg[c][CB_RECV_EMPTY] && !ctl_reg[c][CB_RECV_IRQ] && v16[CB_RECV_IRQ])
                    irq_v[c][IRQ_RECV] = 1'b1;
                if (v16[CB_ERROR])
                    ctl_reg[c][CB_ERROR] = 1'b0;
                mm         = m16 & CTL_WR_MASK;
                ctl_reg[c] = (ctl_reg[c] & ~mm) | (v16 & mm);
            end
            OP_SEND: begin
                if (ctl_reg[c][CB_ENABLE]) begin
                    if (fifo_cnt[c] >= FIFO_DEPTH) begin
                        n_overflow++;
                        ctl_reg[c][CB_ERROR] = 1'b1;
                    end else begin
                        slot               = (fifo_rd[c] + fifo_cnt[c]) % FIFO_DEPTH;
                        fifo_words[c][slot] = a.value & a.mask;
                        fifo_cnt[c]++;
                        if (fifo_cnt[c] == 1) begin
                            ctl_reg[c][CB_SEND_EMPTY] = 1'b0;
                            ctl_reg[o][CB_RECV_EMPTY] = 1'b0;
                            if (ctl_reg[o][CB_RECV_IRQ])
                                irq_v[o][IRQ_RECV] = 1'b1;
                        end else if (fifo_cnt[c] == FIFO_DEPTH) begin
                            n_full++;
                            ctl_reg[c][CB_SEND_FULL] = 1'b1;
                            ctl_reg[o][CB_RECV_FULL] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (fifo_cnt[o] == 0) begin
                    n_underflow++;
                    ctl_reg[c][CB_ERROR] = 1'b1;
                end else begin
                    rx_latch[c] = fifo_words[o][fifo_rd[o]];
                    if (!ctl_reg[c][CB_ENABLE]) begin
                        n_peek++;
                    end else begin
                        fifo_rd[o] = (fifo_rd[o] + 1) % FIFO_DEPTH;
                        fifo_cnt[o]--;
                        if (fifo_cnt[o] == 0) begin
                            ctl_reg[c][CB_RECV_EMPTY] = 1'b1;
                            ctl_reg[o][CB_SEND_EMPTY] = 1'b1;
                            if (ctl_reg[o][CB_SEND_IRQ])
                                irq_v[o][IRQ_SEMPT] = 1'b1;
                        end else if (fifo_cnt[o] == FIFO_DEPTH - 1) begin
                            ctl_reg[c][CB_RECV_FULL] = 1'b0;
                            ctl_reg[o][CB_SEND_FULL] = 1'b0;
                        end
                    end
                end
                r.rdata = rx_latch[c];
            end
        endcase
        r.sync  = sync_reg[c];
        r.ctl   = ctl_reg[c];
        r.irq_a = irq_v[0];
        r.irq_b = irq_v[1];
        return r;
    endfunction

    task automatic add_access(t_op op, logic cpu, logic [31:0] mask, logic [31:0] value);
        t_access a;
        a.op    = op;
        a.cpu   = cpu;
        a.mask  = mask;
        a.value = value;
        if (pend_tail < ITEM_CAP) begin
            pending_mem[pend_tail] = a;
            pend_tail++;
        end
    endtask

    // Random access of a given kind; control writes mostly keep the FIFO enabled.
    task automatic add_random(t_op op, logic cpu);
        logic [31:0] mask;
        logic [31:0] value;
        mask  = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : $urandom();
        value = $urandom();
        if (op == OP_CTRL) begin
            value[CB_CLEAR] = ($urandom_range(3) == 0);
            if ($urandom_range(9) < 8) begin
                value[CB_ENABLE] = 1'b1;
                mask[CB_ENABLE]  = 1'b1;
            end
        end
        add_access(op, cpu, mask, value);
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
        end
    endtask

    // Input driver: holds a beat until it is taken, then offers the next one or idles.
    always @(negedge clk) begin : drive_access
        t_access nxt;
        int      idle_pct;
        if (acc_cnt < PHASE_LEN)
            idle_pct = 8;
        else if (acc_cnt < 2 * PHASE_LEN)
            idle_pct = 77;
        else
            idle_pct = 0;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pend_head < pend_tail && $urandom_range(99) >= idle_pct) begin
                nxt = pending_mem[pend_head];
                pend_head++;
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.value, nxt.mask};
                s_tuser  <= {nxt.cpu, nxt.op};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls per phase, plus one long hold-off to back the block up.
    always @(negedge clk) begin : drive_ready
        int idle_pct;
        if (acc_cnt < PHASE_LEN)
            idle_pct = 77;
        else if (acc_cnt < 2 * PHASE_LEN)
            idle_pct = 8;
        else
            idle_pct = 0;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!stall_done && acc_cnt >= STALL_AT) begin
            stall_done <= 1'b1;
            hold_left  <= STALL_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: predicts on every accepted access and checks every accepted result.
    always @(posedge clk) begin : watch_beats
        t_access         acc;
        t_mailbox_result want;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                acc.op    = t_op'(s_tuser[1:0]);
                acc.cpu   = s_tuser[2];
                acc.mask  = s_tdata[31:0];
                acc.value = s_tdata[63:32];
                op_cnt[acc.op]++;
                if (exp_tail < ITEM_CAP) begin
                    expected_mem[exp_tail] = mailbox_predict(acc);
                    exp_tail++;
                end
                acc_cnt <= acc_cnt + 1;
            end
            if (m_tvalid && m_tready) begin
                beat_cnt <= beat_cnt + 1;
                if (exp_head == exp_tail) begin
                    mismatch_cnt++;
                    $error("result beat 0x%0h arrived with no access outstanding", m_tdata);
                end else begin
                    want = expected_mem[exp_head];
                    exp_head++;
                    check_field("read_data", want.rdata, m_tdata[31:0]);
                    check_field("sync_now", {16'd0, want.sync}, {16'd0, m_tdata[47:32]});
                    check_field("control_now", {16'd0, want.ctl}, {16'd0, m_tdata[63:48]});
                    check_field("irq_first_cpu", {29'd0, want.irq_a}, {29'd0, m_tdata[66:64]});
                    check_field("irq_second_cpu", {29'd0, want.irq_b}, {29'd0, m_tdata[69:67]});
                end
            end
        end
    end

    initial begin
        #(4_000_000);
        $display("[dual_cpu_ipc_sync_and_fifo] ERROR");
        $finish;
    end

    initial begin : stimulus
        int   kind;
        int   len;
        logic cpu;
        mailbox_reset();

        // Directed opening: error paths, IRQ enables, clear, peek, sync mirroring.
        add_access(OP_RECV, 1'b0, 32'h0, 32'h0);                  // receive while empty
        add_access(OP_SEND, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // send while disabled
        add_access(OP_CTRL, 1'b0, 32'h0, 32'h0000_4000);          // unmasked error ack
        add_access(OP_CTRL, 1'b0, 32'hFFFF_FFFF, 32'h0000_8404);  // enable, send-empty and receive IRQs
        add_access(OP_CTRL, 1'b1, 32'h0000_8404, 32'hFFFF_8400);  // enable, receive IRQ
        add_access(OP_CTRL, 1'b0, 32'h0, 32'h0000_0008);          // clear on empty FIFO
        add_access(OP_SEND, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_access(OP_SEND, 1'b0, 32'h0F0F_0F0F, 32'hA5A5_A5A5);
        add_access(OP_CTRL, 1'b1, 32'h0000_8000, 32'h0);          // disable receiver
        add_access(OP_RECV, 1'b1, 32'h0, 32'h0);                  // peek
        add_access(OP_CTRL, 1'b1, 32'h0000_8404, 32'h0000_8400);
        add_access(OP_RECV, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // pop
        add_access(OP_CTRL, 1'b0, 32'h0, 32'h0000_0008);          // clear with data queued
        add_access(OP_RECV, 1'b1, 32'h0, 32'h0);                  // empty again
        add_access(OP_CTRL, 1'b1, 32'h0, 32'h0000_4000);
        add_access(OP_SYNC, 1'b1, 32'h0000_4000, 32'h0000_4000);  // sync IRQ enable
        add_access(OP_SYNC, 1'b0, 32'h0, 32'h0000_2000);          // raw request bit
        add_access(OP_SYNC, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_access(OP_SYNC, 1'b1, 32'hFFFF_FFFF, 32'h0);
        add_access(OP_CTRL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_access(OP_SEND, 1'b1, 32'h0, 32'hFFFF_FFFF);
        add_access(OP_CTRL, 1'b0, 32'h0, 32'h0000_0400);          // receive IRQ bit, already enabled
        add_access(OP_RECV, 1'b0, 32'h0, 32'h0);

        // Random part: mostly send and receive bursts that run the FIFOs full and empty.
        while (pend_tail < ITEM_TARGET) begin
            kind = $urandom_range(9);
            cpu  = 1'($urandom_range(1));
            len  = $urandom_range(1, 20);
            case (kind)
                0, 1, 2: begin
                    repeat (len) add_random(OP_SEND, cpu);
                end
                3, 4, 5: begin
                    repeat (len) add_random(OP_RECV, cpu);
                end
                6: add_random(OP_CTRL, cpu);
                7: add_random(OP_SYNC, cpu);
                default: begin
                    repeat ($urandom_range(1, 4))
                        add_access(t_op'(2'($urandom_range(3))), 1'($urandom_range(1)),
                                   $urandom(), $urandom());
                end
            endcase
        end
        total_items = pend_tail;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (acc_cnt != total_items) @(posedge clk);
        while (exp_head != exp_tail) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d accesses (%0d sync, %0d control, %0d send, %0d receive),",
                 acc_cnt, op_cnt[OP_SYNC], op_cnt[OP_CTRL], op_cnt[OP_SEND], op_cnt[OP_RECV]);
        $display("%0d results; FIFO corners: %0d full, %0d overflow, %0d underflow, %0d peek, %0d clear.",
                 beat_cnt, n_full, n_overflow, n_underflow, n_peek, n_clear);
        if (mismatch_cnt == 0) begin
            $display("[dual_cpu_ipc_sync_and_fifo] OK");
        end else begin
            $display("[dual_cpu_ipc_sync_and_fifo] ERROR");
        end
        $finish;
    end

endmodule
